// File: rtl/irtrc_pkg.sv
// ----------------------------------------------------------------------------
// irtrc_pkg
// Shared codes, constants and the packet error code helper for the
// thermometer read checker.
// ----------------------------------------------------------------------------
package irtrc_pkg;

  // configuration register indexes
  localparam logic REG_BUS_ADDRESS = 1'b0;
  localparam logic REG_UNIT        = 1'b1;

  // register reset values
  localparam logic [6:0] BUS_ADDRESS_RESET = 7'd90;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_PEC_ERROR  = 2'd1,
    STATUS_FLAG_ERROR = 2'd2
  } status_t;

  // output unit codes
  typedef enum logic [1:0] {
    UNIT_RAW        = 2'd0,
    UNIT_KELVIN     = 2'd1,
    UNIT_CELSIUS    = 2'd2,
    UNIT_FAHRENHEIT = 2'd3
  } unit_t;

  // crc-8, polynomial x^8 + x^2 + x + 1, msb first
  localparam logic [7:0] CRC_POLY = 8'h07;

  // fixed point offsets in hundredths of a degree
  localparam logic signed [17:0] KELVIN_OFFSET_CENTI     = 18'sd27315;
  localparam logic signed [18:0] FAHRENHEIT_OFFSET_CENTI = 19'sd3200;

  // reciprocal of five scaled by 2^22, exact for magnitudes below 2^20
  localparam int unsigned RECIP5_SHIFT = 22;
  localparam logic [21:0] RECIP5       = 22'd838861;

  // one byte through the crc register
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] v;
    v = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (v[7]) begin
        v = {v[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

// File: rtl/ir_thermometer_read_checker.sv
// ----------------------------------------------------------------------------
// ir_thermometer_read_checker
// Checks the packet error code of one sensor read-word transaction and
// converts the word into the configured temperature unit.
// Path: an accepted transfer passes the input register and then the result
// register, which shows its result with done high.
// Throughput: one transfer per cycle; busy stays low, the two-register path
// (input register, result register) takes a new transfer every cycle.
// Reset: synchronous rst clears the pipeline valid bits and sets bus_address
// to 90 and unit to Celsius.
// ----------------------------------------------------------------------------
module ir_thermometer_read_checker
  import irtrc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // configuration write port
  input  logic               wr_en,
  input  logic               wr_index,
  input  logic [6:0]         wr_data,
  // command side
  input  logic               start,
  output logic               busy,
  input  logic [7:0]         command,
  input  logic [7:0]         data_low,
  input  logic [7:0]         data_high,
  input  logic [7:0]         pec_byte,
  input  logic               check_flag,
  // result side
  output logic               done,
  output logic [1:0]         status,
  output logic signed [15:0] raw_word,
  output logic signed [18:0] temperature,
  output logic [7:0]         computed_pec
);

  // configuration registers
  logic [6:0] bus_address;
  unit_t      unit;

  // input register
  logic       in_valid;
  logic [7:0] command_q;
  logic [7:0] data_low_q;
  logic [7:0] data_high_q;
  logic [7:0] pec_byte_q;
  logic       check_flag_q;

  // combinational result
  logic [7:0]         crc;
  logic signed [15:0] word_s;
  logic signed [17:0] centi;
  logic signed [20:0] centi_ext;
  logic signed [20:0] scaled;
  logic signed [20:0] scaled_neg;
  logic [19:0]        mag;
  logic [41:0]        prod;
  logic [17:0]        quot;
  logic signed [18:0] quot_s;
  logic signed [18:0] fahr;
  logic signed [18:0] conv;
  status_t            status_next;
  logic signed [18:0] temperature_next;

  // no stall inside the block
  assign busy = 1'b0;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      bus_address <= BUS_ADDRESS_RESET;
      unit        <= UNIT_CELSIUS;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_BUS_ADDRESS: bus_address <= wr_data;
        REG_UNIT:        unit        <= unit_t'(wr_data[1:0]);
      endcase
    end
  end

  // capture a transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      command_q    <= command;
      data_low_q   <= data_low;
      data_high_q  <= data_high;
      pec_byte_q   <= pec_byte;
      check_flag_q <= check_flag;
    end
  end

  // packet error code over write address, command, read address, data
  always_comb begin
    crc = crc8_byte(8'h00, {bus_address, 1'b0});
    crc = crc8_byte(crc, command_q);
    crc = crc8_byte(crc, {bus_address, 1'b1});
    crc = crc8_byte(crc, data_low_q);
    crc = crc8_byte(crc, data_high_q);
  end

  // unit conversion
  assign word_s     = {data_high_q, data_low_q};
  assign centi      = {word_s[15], word_s, 1'b0} - KELVIN_OFFSET_CENTI;
  assign centi_ext  = {{3{centi[17]}}, centi};
  assign scaled     = (centi_ext <<< 3) + centi_ext;
  assign scaled_neg = -scaled;
  assign mag        = scaled[20] ? scaled_neg[19:0] : scaled[19:0];
  assign prod       = 42'(mag) * 42'(RECIP5);
  assign quot       = prod[RECIP5_SHIFT+17:RECIP5_SHIFT];
  assign quot_s     = scaled[20] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
  assign fahr       = quot_s + FAHRENHEIT_OFFSET_CENTI;

  always_comb begin
    unique case (unit)
      UNIT_RAW:        conv = {{3{word_s[15]}}, word_s};
      UNIT_KELVIN:     conv = {{2{word_s[15]}}, word_s, 1'b0};
      UNIT_CELSIUS:    conv = {centi[17], centi};
      UNIT_FAHRENHEIT: conv = fahr;
      default:         conv = '0;
    endcase
  end

  // status priority: checksum first, then the error flag
  always_comb begin
    temperature_next = '0;
    priority if (crc != pec_byte_q) begin
      status_next = STATUS_PEC_ERROR;
    end else if (check_flag_q && data_high_q[7]) begin
      status_next = STATUS_FLAG_ERROR;
    end else begin
      status_next      = STATUS_OK;
      temperature_next = conv;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      status       <= status_next;
      raw_word     <= word_s;
      temperature  <= temperature_next;
      computed_pec <= crc;
    end
  end

endmodule

// File: rtl/irtrc_checker.sv
// ----------------------------------------------------------------------------
// irtrc_checker
// Port-level checks on the thermometer read checker, bound to the top level.
// ----------------------------------------------------------------------------
module irtrc_checker
  import irtrc_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic [7:0]         pec_byte,
  input logic               check_flag,
  input logic               done,
  input logic [1:0]         status,
  input logic signed [15:0] raw_word,
  input logic signed [18:0] temperature,
  input logic [7:0]         computed_pec
);

  // every accepted transfer yields a result through the input and result registers
  a_accept_to_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("accepted transfer produced no result");

  // no result without an accepted transfer
  a_done_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result without accepted transfer");

  // an error result carries zero temperature
  a_error_zero_temp: assert property (@(posedge clk) disable iff (rst)
    (done && status != STATUS_OK) |-> (temperature == '0))
    else $error("error result with nonzero temperature");

  // an ok result matched the received code
  a_ok_pec_match: assert property (@(posedge clk) disable iff (rst)
    (done && status == STATUS_OK) |-> (computed_pec == $past(pec_byte, 2)))
    else $error("ok status with mismatched packet error code");

  // a flag error needs bit 15 of the word
  a_flag_bit: assert property (@(posedge clk) disable iff (rst)
    (done && status == STATUS_FLAG_ERROR) |-> (raw_word[15] && $past(check_flag, 2)))
    else $error("flag error without flag bit");

endmodule

bind ir_thermometer_read_checker irtrc_checker u_irtrc_checker (.*);

// File: tb/read_result_checker.sv
// ----------------------------------------------------------------------------
// read_result_checker
// Watches the configuration writes and both transfer channels of the
// thermometer read checker. Each accepted transaction yields a predicted
// reading, and each reading the block returns is compared field by field
// with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
package read_check_tb_pkg;

  import irtrc_pkg::*;

  // one predicted result
  typedef struct {
    status_t            status;
    logic signed [15:0] word;
    logic signed [18:0] temp;
    logic [7:0]         pec;
  } reading_t;

  // packet error code over the five-byte read frame, shifted in bit by bit
  function automatic logic [7:0] frame_pec(input logic [6:0] addr, input logic [7:0] cmd,
                                           input logic [7:0] lo, input logic [7:0] hi);
    logic [39:0] frame;
    logic [7:0]  crc;
    logic        fb;
    frame = {addr, 1'b0, cmd, addr, 1'b1, lo, hi};
    crc = 8'h00;
    for (int i = 39; i >= 0; i--) begin
      fb = crc[7] ^ frame[i];
      crc = {crc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return crc;
  endfunction

endpackage

module read_result_checker
  import irtrc_pkg::*;
  import read_check_tb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic               wr_index,
  input  logic [6:0]         wr_data,
  input  logic               start,
  input  logic               busy,
  input  logic [7:0]         command,
  input  logic [7:0]         data_low,
  input  logic [7:0]         data_high,
  input  logic [7:0]         pec_byte,
  input  logic               check_flag,
  input  logic               done,
  input  logic [1:0]         status,
  input  logic signed [15:0] raw_word,
  input  logic signed [18:0] temperature,
  input  logic [7:0]         computed_pec,
  output int                 failures,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [6:0] addr_q;
  unit_t      unit_q;
  reading_t   readings_q[$];

  // signed count to hundredths of the selected unit, or unchanged for raw
  function automatic int to_centi(input unit_t u, input int r);
    int c;
    c = 2 * r;
    case (u)
      UNIT_RAW:    c = r;
      UNIT_KELVIN: c = 2 * r;
      UNIT_CELSIUS: c = c - int'(KELVIN_OFFSET_CENTI);
      default: c = (c - int'(KELVIN_OFFSET_CENTI)) * 9 / 5 + int'(FAHRENHEIT_OFFSET_CENTI);
    endcase
    return c;
  endfunction

  function automatic reading_t predict_reading(input logic [7:0] cmd, input logic [7:0] lo,
                                               input logic [7:0] hi, input logic [7:0] pec,
                                               input logic chk);
    reading_t rd;
    int       t;
    rd.word = {hi, lo};
    rd.pec = frame_pec(addr_q, cmd, lo, hi);
    t = 0;
    if (rd.pec != pec) begin
      rd.status = STATUS_PEC_ERROR;
    end else if (chk && hi[7]) begin
      rd.status = STATUS_FLAG_ERROR;
    end else begin
      rd.status = STATUS_OK;
      t = to_centi(unit_q, int'(rd.word));
    end
    rd.temp = t[18:0];
    return rd;
  endfunction

  task automatic flag_mismatch(input string field, input int want, input int got);
    $error("%s: expected %0d, got %0d", field, want, got);
    failures++;
  endtask

  always @(posedge clk) begin : watch
    reading_t want;
    if (rst) begin
      addr_q = BUS_ADDRESS_RESET;
      unit_q = UNIT_CELSIUS;
      readings_q.delete();
    end else begin
      // result transfer against the oldest prediction
      if (done === 1'b1) begin
        if (readings_q.size() == 0) begin
          $error("result transfer with no transaction outstanding");
          failures++;
        end else begin
          want = readings_q.pop_front();
          if (status !== want.status) flag_mismatch("status", want.status, status);
          if (raw_word !== want.word) flag_mismatch("raw_word", want.word, raw_word);
          if (temperature !== want.temp) flag_mismatch("temperature", want.temp, temperature);
          if (computed_pec !== want.pec) flag_mismatch("computed_pec", want.pec, computed_pec);
        end
      end
      // register writes
      if (wr_en) begin
        if (wr_index == REG_BUS_ADDRESS) begin
          addr_q = wr_data;
        end else begin
          unit_q = unit_t'(wr_data[1:0]);
        end
      end
      // command transfer
      if (start && !busy) begin
        readings_q.push_back(predict_reading(command, data_low, data_high, pec_byte,
                                             check_flag));
      end
    end
    pending = readings_q.size();
  end

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives read-word transactions into the thermometer read checker: a directed
// set of edge cases under several address and unit settings, then randomized
// phases of mostly well-formed frames with random content plus corrupted
// checksums, with random idle gaps in some phases. The checker beside the block does all
// prediction and comparison.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import irtrc_pkg::*;
  import read_check_tb_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 110;
  localparam int TAIL_CYCLES   = 8;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               wr_en = 1'b0;
  logic               wr_index = REG_BUS_ADDRESS;
  logic [6:0]         wr_data = '0;
  logic               start = 1'b0;
  logic               busy;
  logic [7:0]         command = '0;
  logic [7:0]         data_low = '0;
  logic [7:0]         data_high = '0;
  logic [7:0]         pec_byte = '0;
  logic               check_flag = 1'b0;
  logic               done;
  logic [1:0]         status;
  logic signed [15:0] raw_word;
  logic signed [18:0] temperature;
  logic [7:0]         computed_pec;
  int                 failures;
  int                 pending;

  logic       accepted_q = 1'b0;
  logic [6:0] cur_addr = BUS_ADDRESS_RESET;
  int         cycles = 0;

  ir_thermometer_read_checker dut (
    .clk, .rst, .wr_en, .wr_index, .wr_data, .start, .busy,
    .command, .data_low, .data_high, .pec_byte, .check_flag,
    .done, .status, .raw_word, .temperature, .computed_pec
  );

  read_result_checker check (
    .clk, .rst, .wr_en, .wr_index, .wr_data, .start, .busy,
    .command, .data_low, .data_high, .pec_byte, .check_flag,
    .done, .status, .raw_word, .temperature, .computed_pec,
    .failures, .pending
  );

  always #5 clk = ~clk;

  // command transfer seen at the edge, read back at the next falling edge
  always @(posedge clk) begin
    accepted_q <= start && !busy;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // present one transaction and hold it until the block takes it
  task automatic send_frame(input logic [7:0] cmd, input logic [7:0] lo, input logic [7:0] hi,
                            input logic [7:0] pec, input logic chk);
    command = cmd;
    data_low = lo;
    data_high = hi;
    pec_byte = pec;
    check_flag = chk;
    start = 1'b1;
    do @(negedge clk); while (!accepted_q);
  endtask

  task automatic send_good(input logic [7:0] cmd, input logic [15:0] w, input logic chk);
    send_frame(cmd, w[7:0], w[15:8], frame_pec(cur_addr, cmd, w[7:0], w[15:8]), chk);
  endtask

  task automatic send_corrupt(input logic [7:0] cmd, input logic [15:0] w,
                              input logic [7:0] flip, input logic chk);
    send_frame(cmd, w[7:0], w[15:8], frame_pec(cur_addr, cmd, w[7:0], w[15:8]) ^ flip, chk);
  endtask

  // when enabled, one time in four, drop start for a random idle gap
  task automatic maybe_idle(input logic enable);
    if (enable && $urandom_range(0, 3) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
  endtask

  task automatic drain();
    start = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // both registers, written only with nothing in flight; unit gets junk above its bits
  task automatic configure(input logic [6:0] addr, input unit_t u);
    logic [4:0] junk;
    junk = 5'($urandom);
    drain();
    wr_en = 1'b1;
    wr_index = REG_BUS_ADDRESS;
    wr_data = addr;
    @(negedge clk);
    wr_index = REG_UNIT;
    wr_data = {junk, u};
    @(negedge clk);
    wr_en = 1'b0;
    cur_addr = addr;
  endtask

  // mostly valid frames, some with a broken or random checksum
  task automatic random_item();
    logic [15:0] w;
    logic [7:0]  cmd;
    logic        chk;
    int          pick;
    cmd = 8'($urandom);
    chk = 1'($urandom);
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0: w = 16'h0000;
          1: w = 16'h7FFF;
          2: w = 16'h8000;
          default: w = 16'hFFFF;
        endcase
      end
      default: w = 16'($urandom);
    endcase
    pick = $urandom_range(0, 9);
    if (pick < 8) begin
      send_good(cmd, w, chk);
    end else if (pick == 8) begin
      send_corrupt(cmd, w, 8'($urandom_range(1, 255)), chk);
    end else begin
      send_frame(cmd, w[7:0], w[15:8], 8'($urandom), chk);
    end
  endtask

  initial begin
    logic [6:0] addr;
    logic       idle_on;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // reset settings: address 90, Celsius
    send_good(8'h07, 16'h0000, 1'b0);
    maybe_idle(1'b1);
    send_good(8'h07, 16'h7FFF, 1'b1);
    send_good(8'h07, 16'h8000, 1'b1);
    maybe_idle(1'b1);
    send_good(8'h07, 16'h8000, 1'b0);
    // checksum error takes priority over a set flag
    send_corrupt(8'hFF, 16'hFFFF, 8'hFF, 1'b1);
    send_corrupt(8'h00, 16'hAA55, 8'h01, 1'b0);

    // top address, write address wraps to 0xfe; raw counts
    configure(7'd127, UNIT_RAW);
    send_good(8'h06, 16'h8000, 1'b0);
    send_good(8'h06, 16'h7FFF, 1'b0);
    maybe_idle(1'b1);
    send_good(8'h06, 16'hFFFF, 1'b0);

    // address zero, kelvin
    configure(7'd0, UNIT_KELVIN);
    send_good(8'h07, 16'h8000, 1'b0);
    send_good(8'h07, 16'h7FFF, 1'b1);
    send_good(8'h07, 16'h3A98, 1'b1);

    // fahrenheit, including truncation of small negative values toward zero
    configure(7'd64, UNIT_FAHRENHEIT);
    send_good(8'h07, 16'h8000, 1'b0);
    send_good(8'h07, 16'h7FFF, 1'b0);
    maybe_idle(1'b1);
    send_good(8'h07, 16'h3559, 1'b1);
    send_good(8'h07, 16'h3558, 1'b1);
    send_good(8'h07, 16'h355A, 1'b0);
    send_good(8'h07, 16'hFFFF, 1'b0);
    send_corrupt(8'h07, 16'h3AAC, 8'h80, 1'b0);

    // random phases; the last ones run with no gaps
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0) addr = 7'd0;
      else if (p == 1) addr = 7'd127;
      else addr = 7'($urandom_range(0, 127));
      configure(addr, unit_t'(p % 4));
      idle_on = (p < RANDOM_PHASES - 2) && (p % 3 != 2);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        random_item();
        maybe_idle(idle_on);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (failures == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
